// ----- rtl/tgs_pkg.sv -----
// Shared types and constants of the truncated Gaussian table sampler.
// No dependencies; the core, the bound scanner and the checker import this package.
`default_nettype none

package tgs_pkg;

  // Request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Truncation mode codes (the unused code behaves as no truncation)
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_BELOW  = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CUTOFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CUTOFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUNC_MODE   = 3'd4;

  // Register widths and reset values
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CUT_W   = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned UNI_W   = 16;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_IDX_W = 8;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
  localparam logic [CUT_W-1:0]   LOWER_RST = 32'h8000_0000;
  localparam logic [CUT_W-1:0]   UPPER_RST = 32'h7FFF_FFFF;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCALE,
    ST_READ,
    ST_OUT
  } tgs_state_e;

  // Top level to bound scanner
  typedef struct packed {
    logic start;
    logic two_sided;
  } scan_ctl_t;

  // Bound scanner to top level
  typedef struct packed {
    logic rd_en;
    logic done;
  } scan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tgs_if.sv -----
// Request and result channel interfaces of the truncated Gaussian table sampler.
// Plain valid/ready channels; no package dependency.
`default_nettype none

interface tgs_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         entry_index;
  logic signed [15:0] entry_value;
  logic [15:0]        uniform;

  modport source (output valid, operation, entry_index, entry_value, uniform,
                  input ready);
  modport sink   (input valid, operation, entry_index, entry_value, uniform,
                  output ready);
endinterface

interface tgs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic [7:0]         chosen_index;

  modport source (output valid, sample, chosen_index, input ready);
  modport sink   (input valid, sample, chosen_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/truncated_gaussian_table_sampler_core.sv -----
// Truncated Gaussian table sampler. A load request writes one Q3.12 quantile
// into the table memory and returns nothing. A draw request returns scale
// times the chosen entry as a Q11.20 sample plus the index used, after the
// index multiply (ST_SCALE), the index add and table read (ST_READ) and the
// sample multiply into the output register (ST_OUT). The request side stays
// closed until then, so a draw is not taken before the last one has reached
// the output register; loads are taken once per cycle while idle. With
// truncation on, the first draw after any load or register write first scans
// the table through the memory's single read port, one entry per cycle. The
// result sits in an output register, and the next request is taken while it
// waits. The table is undefined until written; there is no clearing pass.
`default_nettype none

module truncated_gaussian_table_sampler_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tgs_req_if.sink                              req_i,
  tgs_rsp_if.source                            rsp_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tgs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tgs_pkg::CUT_W-1:0]       cfg_wdata_i
);

  import tgs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SZ_W   = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int unsigned POS_W  = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;
  localparam int unsigned PROD_W = CNT_W + UNI_W + 2;

  tgs_state_e state_q, state_d;

  logic [SIZE_W-1:0]       table_size_q;
  logic [SCALE_W-1:0]      scale_q;
  logic [CUT_W-1:0]        lower_q, upper_q;
  logic [MODE_W-1:0]       mode_q;
  logic                    bounds_ok_q;
  logic [UNI_W-1:0]        uni_q;
  logic [CNT_W-1:0]        base_q;
  logic signed [PROD_W-1:0] dprod_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [OUT_IDX_W-1:0]    out_index_q;

  logic                    accept, draw_acc, load_acc, load_ok;
  logic                    trunc_below, trunc_both, trunc_on;
  logic [SZ_W-1:0]         size_ext;
  logic [CNT_W-1:0]        n_eff;
  logic                    out_free;

  scan_ctl_t               scan_ctl;
  scan_stat_t              scan_stat;
  logic [IDX_W-1:0]        scan_addr, low_idx, high_idx;

  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic [CNT_W-1:0]        base_a, bound_b;
  logic signed [CNT_W:0]   span;
  logic signed [PROD_W-1:0] dprod_d;
  logic signed [PROD_W-1:0] quot;
  logic signed [CNT_W+1:0] pos_sum;
  logic [CNT_W-1:0]        pos_u, pos_clamp;
  logic signed [SAMPLE_W:0] sample_full;
  logic                    out_load;

  // Handshake and operation decode
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign draw_acc    = accept && (req_i.operation == OP_DRAW);
  assign load_acc    = accept && (req_i.operation == OP_LOAD);
  assign load_ok     = load_acc && (POS_W'(req_i.entry_index) < POS_W'(TABLE_DEPTH));

  assign trunc_below = (mode_q == MODE_BELOW);
  assign trunc_both  = (mode_q == MODE_BOTH);
  assign trunc_on    = trunc_below || trunc_both;

  // Effective table size, clamped to the usable range
  assign size_ext = SZ_W'(table_size_q);
  always_comb begin
    if (size_ext < SZ_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (size_ext > SZ_W'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(size_ext);
    end
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (draw_acc) begin
          state_d = (trunc_on && !bounds_ok_q) ? ST_SCAN : ST_SCALE;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_READ;
      ST_READ:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    scan_ctl.start     = 1'b0;
    scan_ctl.two_sided = trunc_both;
    ram_re             = 1'b0;
    ram_raddr          = scan_addr;
    out_load           = 1'b0;
    unique case (state_q)
      ST_IDLE: scan_ctl.start = draw_acc && trunc_on && !bounds_ok_q;
      ST_SCAN: ram_re = scan_stat.rd_en;
      ST_SCALE: ;
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = pos_clamp[IDX_W-1:0];
      end
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // Index span times uniform fraction
  always_comb begin
    base_a  = trunc_on ? CNT_W'(low_idx) : '0;
    bound_b = trunc_both ? CNT_W'(high_idx) : n_eff;
    span    = $signed({1'b0, bound_b}) - $signed({1'b0, base_a});
    dprod_d = span * $signed({1'b0, uni_q});
  end

  // Floor of the product, add the base, clamp below the size
  always_comb begin
    quot    = dprod_q >>> UNI_W;
    pos_sum = $signed({2'b00, base_q}) + $signed(quot[CNT_W+1:0]);
    pos_u   = pos_sum[CNT_W-1:0];
    pos_clamp = (pos_u >= n_eff) ? (n_eff - CNT_W'(1)) : pos_u;
  end

  assign sample_full = $signed({1'b0, scale_q}) * $signed(ram_rdata);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_size_q <= SIZE_RST;
      scale_q      <= SCALE_RST;
      lower_q      <= LOWER_RST;
      upper_q      <= UPPER_RST;
      mode_q       <= MODE_NONE;
      bounds_ok_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // Write configuration; any write drops the found bounds
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TABLE_SIZE:   table_size_q <= cfg_wdata_i[SIZE_W-1:0];
          CFG_SCALE:        scale_q      <= cfg_wdata_i[SCALE_W-1:0];
          CFG_LOWER_CUTOFF: lower_q      <= cfg_wdata_i;
          CFG_UPPER_CUTOFF: upper_q      <= cfg_wdata_i;
          CFG_TRUNC_MODE:   mode_q       <= cfg_wdata_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we_i || load_acc) begin
        bounds_ok_q <= 1'b0;
      end else if ((state_q == ST_SCAN) && scan_stat.done) begin
        bounds_ok_q <= 1'b1;
      end
      // Hold the result until taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (draw_acc) begin
      uni_q <= req_i.uniform;
    end
    if (state_q == ST_SCALE) begin
      base_q  <= base_a;
      dprod_q <= dprod_d;
    end
    if (state_q == ST_READ) begin
      idx_q <= pos_clamp[IDX_W-1:0];
    end
    if (out_load) begin
      sample_q    <= sample_full[SAMPLE_W-1:0];
      out_index_q <= OUT_IDX_W'(idx_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.sample       = sample_q;
  assign rsp_o.chosen_index = out_index_q;

  tgs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (IDX_W'(req_i.entry_index)),
    .wdata_i (req_i.entry_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tgs_scan #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .size_i     (n_eff),
    .scale_i    (scale_q),
    .lower_i    ($signed(lower_q)),
    .upper_i    ($signed(upper_q)),
    .rd_addr_o  (scan_addr),
    .rd_data_i  (ram_rdata),
    .stat_o     (scan_stat),
    .low_idx_o  (low_idx),
    .high_idx_o (high_idx)
  );

endmodule

`default_nettype wire

// ----- rtl/tgs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tgs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tgs_scan.sv -----
// Cutoff bound scanner: walks the quantile table once, one entry per cycle,
// and finds the first scaled entry at or above the lower cutoff and the last at or
// below the upper cutoff. Depends on tgs_pkg; reads through the table RAM.
`default_nettype none

module tgs_scan #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire tgs_pkg::scan_ctl_t                     ctl_i,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]       size_i,
  input  wire logic [tgs_pkg::SCALE_W-1:0]            scale_i,
  input  wire logic signed [tgs_pkg::CUT_W-1:0]       lower_i,
  input  wire logic signed [tgs_pkg::CUT_W-1:0]       upper_i,
  output logic      [$clog2(TABLE_DEPTH)-1:0]         rd_addr_o,
  input  wire logic [tgs_pkg::ENTRY_W-1:0]            rd_data_i,
  output tgs_pkg::scan_stat_t                         stat_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]         low_idx_o,
  output logic      [$clog2(TABLE_DEPTH)-1:0]         high_idx_o
);

  import tgs_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                    run_q, fin_q, done_q;
  logic [CNT_W-1:0]        issue_q, n_q;
  logic                    v1_q, last1_q, v2_q, last2_q;
  logic [IDX_W-1:0]        k1_q, k2_q;
  logic signed [CUT_W-1:0] prod2_q, lo_q, hi_q;
  logic                    two_q;
  logic                    lo_found_q, hi_found_q;
  logic [IDX_W-1:0]        lo_idx_q, hi_idx_q;
  logic [IDX_W-1:0]        low_q, high_q;

  logic                    issue;
  logic                    issue_last;
  logic [CNT_W-1:0]        n_m1;
  logic signed [CUT_W:0]   prod_full;
  logic                    swap;
  logic [IDX_W-1:0]        lo_sel, hi_sel, lo_fix, hi_fix;

  // Issue one read per cycle until the whole active table is covered
  assign n_m1       = n_q - CNT_W'(1);
  assign issue      = run_q && (issue_q < n_q);
  assign issue_last = (issue_q == n_m1);
  assign rd_addr_o  = issue_q[IDX_W-1:0];

  // Scaled entry of the data that arrives from the RAM
  assign prod_full = $signed({1'b0, scale_i}) * $signed(rd_data_i);

  // Swap reversed cutoffs only for two-sided truncation
  assign swap = ctl_i.two_sided && (upper_i < lower_i);

  // Default bounds when nothing matched, then separate equal bounds when two-sided
  always_comb begin
    lo_sel = lo_found_q ? lo_idx_q : n_m1[IDX_W-1:0];
    hi_sel = hi_found_q ? hi_idx_q : '0;
    lo_fix = lo_sel;
    hi_fix = hi_sel;
    if (two_q && (lo_sel == hi_sel)) begin
      if (lo_sel == '0) begin
        hi_fix = IDX_W'(1);
      end else begin
        lo_fix = hi_sel - IDX_W'(1);
      end
    end
  end

  // Control: run, pipeline valids, finish and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      fin_q      <= 1'b0;
      done_q     <= 1'b0;
      issue_q    <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      lo_found_q <= 1'b0;
      hi_found_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      v1_q   <= issue;
      v2_q   <= v1_q;
      if (ctl_i.start) begin
        run_q      <= 1'b1;
        issue_q    <= '0;
        lo_found_q <= 1'b0;
        hi_found_q <= 1'b0;
      end else begin
        if (issue) begin
          issue_q <= issue_q + CNT_W'(1);
        end
        if (v2_q) begin
          if (!lo_found_q && (prod2_q >= lo_q)) begin
            lo_found_q <= 1'b1;
          end
          if (prod2_q <= hi_q) begin
            hi_found_q <= 1'b1;
          end
          if (last2_q) begin
            run_q <= 1'b0;
            fin_q <= 1'b1;
          end
        end
        if (fin_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: cutoffs, stage indexes, products and found positions
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      n_q   <= size_i;
      two_q <= ctl_i.two_sided;
      lo_q  <= swap ? upper_i : lower_i;
      hi_q  <= swap ? lower_i : upper_i;
    end
    k1_q    <= rd_addr_o;
    last1_q <= issue_last;
    k2_q    <= k1_q;
    last2_q <= last1_q;
    prod2_q <= prod_full[CUT_W-1:0];
    if (v2_q && !lo_found_q && (prod2_q >= lo_q)) begin
      lo_idx_q <= k2_q;
    end
    if (v2_q && (prod2_q <= hi_q)) begin
      hi_idx_q <= k2_q;
    end
    if (fin_q) begin
      low_q  <= lo_fix;
      high_q <= hi_fix;
    end
  end

  assign stat_o.rd_en = issue;
  assign stat_o.done  = done_q;
  assign low_idx_o    = low_q;
  assign high_idx_o   = high_q;

endmodule

`default_nettype wire

// ----- rtl/tgs_checker.sv -----
// Port-level checks of the truncated Gaussian table sampler, bound to the
// top level. Depends on tgs_pkg and truncated_gaussian_table_sampler_core.
`default_nettype none

module tgs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic req_operation_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i
);

  import tgs_pkg::*;

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // A waiting result is not withdrawn
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn before it was taken");

  // A draw closes the request side while it is worked on
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_operation_i == OP_DRAW) |=> !req_ready_i)
    else $error("request taken while a draw is in progress");

  // No result appears in the cycle after any request into an empty output
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && !rsp_valid_i |=> !rsp_valid_i)
    else $error("result appeared too early or without a draw");

  // A new result comes only out of a busy cycle
  a_rsp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result raised while the block was idle");

endmodule

bind truncated_gaussian_table_sampler_core tgs_checker u_tgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_operation_i (req_i.operation),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready)
);

`default_nettype wire
